// ----- rtl/ps2mt_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ps2mt_pkg
// shared types, constants and helpers of the ps/2 mouse packet tracker
// ---------------------------------------------------------------------------
package ps2mt_pkg;

    localparam int RING_DEPTH_DEF = 16;

    localparam int AXIS_W  = 16;
    localparam int DELTA_W = 8;
    localparam int BTN_W   = 3;
    localparam int CNT_W   = 4;
    localparam int OP_W    = 2;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_Y = 1'b1;

    localparam logic [AXIS_W-1:0] MAX_X_RESET = 16'd1023;
    localparam logic [AXIS_W-1:0] MAX_Y_RESET = 16'd767;

    localparam logic [7:0] SYNC_BIT_MASK = 8'h08;

    localparam logic [OP_W-1:0] OP_BYTE = 2'd0;
    localparam logic [OP_W-1:0] OP_POP  = 2'd1;
    localparam logic [OP_W-1:0] OP_SET  = 2'd2;

    typedef enum logic [1:0] {
        CMD_BYTE,
        CMD_POP,
        CMD_SET,
        CMD_IDLE
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind         kind;
        logic [7:0]        data;
        logic [AXIS_W-1:0] x;
        logic [AXIS_W-1:0] y;
    } t_cmd_word;

    typedef enum logic [1:0] {
        PH_SYNC   = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } t_phase;

    typedef struct packed {
        logic [AXIS_W-1:0]  x;
        logic [AXIS_W-1:0]  y;
        logic [DELTA_W-1:0] dx;
        logic [DELTA_W-1:0] dy;
        logic [BTN_W-1:0]   btn;
    } t_ring_entry;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    // clamp a signed sum into 0..hi
    function automatic logic [AXIS_W-1:0] clamp_axis(
        input logic signed [AXIS_W+1:0] v,
        input logic [AXIS_W-1:0]        hi
    );
        logic [AXIS_W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > $signed({2'b00, hi})) begin
            res = hi;
        end else begin
            res = v[AXIS_W-1:0];
        end
        return res;
    endfunction

endpackage

// ----- rtl/ps2mt_front.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ps2mt_front
// input handshake, operation decode and a two-entry command queue
// ---------------------------------------------------------------------------
module ps2mt_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [ps2mt_pkg::OP_W-1:0]   i_operation,
    input  logic [7:0]                   i_data_byte,
    input  logic [ps2mt_pkg::AXIS_W-1:0] i_new_x,
    input  logic [ps2mt_pkg::AXIS_W-1:0] i_new_y,
    output logic                         o_q_valid,
    output ps2mt_pkg::t_cmd_word         o_q_word,
    input  logic                         i_q_pop
);
    import ps2mt_pkg::*;

    localparam int QD    = 2;
    localparam int QAW   = $clog2(QD);
    localparam int QCW   = $clog2(QD + 1);

    t_cmd_word          r_q [QD];
    logic [QAW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [QAW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [QCW-1:0]     r_cnt, n_cnt;
    t_cmd_word          dec_word;
    logic               push;

    // classify the incoming word
    always_comb begin
        dec_word.data = i_data_byte;
        dec_word.x    = i_new_x;
        dec_word.y    = i_new_y;
        unique case (i_operation)
            OP_BYTE: dec_word.kind = CMD_BYTE;
            OP_POP:  dec_word.kind = CMD_POP;
            OP_SET:  dec_word.kind = CMD_SET;
            default: dec_word.kind = CMD_IDLE;
        endcase
    end

    assign o_in_ready = (r_cnt != QCW'(QD));
    assign push       = i_in_valid && o_in_ready;
    assign o_q_valid  = (r_cnt != '0);
    assign o_q_word   = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QAW'(QD - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_q_pop) begin
            n_rd_ptr = (r_rd_ptr == QAW'(QD - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !i_q_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!push && i_q_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= dec_word;
        end
    end

endmodule

// ----- rtl/ps2mt_back.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ps2mt_back
// packet phase machine, cursor tracker, packet ring and result register
// ---------------------------------------------------------------------------
module ps2mt_back #(
    parameter int RING_DEPTH = ps2mt_pkg::RING_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ps2mt_pkg::t_cfg_wr                  i_cfg,
    input  logic                                i_q_valid,
    input  ps2mt_pkg::t_cmd_word                i_q_word,
    output logic                                o_q_pop,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_packet_valid,
    output logic [ps2mt_pkg::AXIS_W-1:0]        o_pos_x,
    output logic [ps2mt_pkg::AXIS_W-1:0]        o_pos_y,
    output logic signed [ps2mt_pkg::DELTA_W-1:0] o_delta_x,
    output logic signed [ps2mt_pkg::DELTA_W-1:0] o_delta_y,
    output logic [ps2mt_pkg::BTN_W-1:0]         o_buttons,
    output logic [ps2mt_pkg::CNT_W-1:0]         o_queued_count,
    output logic                                o_dropped
);
    import ps2mt_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);

    // configuration
    logic [AXIS_W-1:0] r_max_x, r_max_y;

    // architectural state
    t_phase            r_phase, n_phase;
    logic [7:0]        r_first, n_first;
    logic [7:0]        r_second, n_second;
    logic [AXIS_W-1:0] r_cur_x, n_cur_x;
    logic [AXIS_W-1:0] r_cur_y, n_cur_y;
    logic [AW-1:0]     r_wr_idx, n_wr_idx;
    logic [AW-1:0]     r_rd_idx, n_rd_idx;

    t_ring_entry       r_mem [RING_DEPTH];
    t_ring_entry       r_rd_data;
    t_ring_entry       wr_entry;

    // result register
    logic              r_out_valid;
    logic              r_out_hit, n_out_hit;
    logic              r_out_drop, n_out_drop;
    logic [CNT_W-1:0]  r_out_count;

    logic                     fire;
    logic                     ring_we;
    logic                     ring_empty;
    logic                     ring_full;
    logic                     pkt_done;
    logic [AW-1:0]            wr_next;
    logic [AW-1:0]            rd_next;
    logic signed [AXIS_W+1:0] sum_x;
    logic signed [AXIS_W+1:0] sum_y;
    logic [AW:0]              cnt_ext;
    logic [AW+CNT_W-1:0]      cnt_wide;

    assign fire    = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_q_pop = fire;

    assign wr_next    = (r_wr_idx == AW'(RING_DEPTH - 1)) ? '0 : r_wr_idx + 1'b1;
    assign rd_next    = (r_rd_idx == AW'(RING_DEPTH - 1)) ? '0 : r_rd_idx + 1'b1;
    assign ring_empty = (r_rd_idx == r_wr_idx);
    assign ring_full  = (wr_next == r_rd_idx);

    assign pkt_done = fire && (i_q_word.kind == CMD_BYTE) && (r_phase == PH_THIRD);

    // x moves by the second byte, y by the third byte
    assign sum_x = $signed({2'b00, r_cur_x})
                 + (AXIS_W+2)'($signed(r_second));
    assign sum_y = $signed({2'b00, r_cur_y})
                 - (AXIS_W+2)'($signed(i_q_word.data));

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (fire && (i_q_word.kind == CMD_BYTE)) begin
            unique case (r_phase)
                PH_SECOND: n_phase = PH_THIRD;
                PH_THIRD:  n_phase = PH_SYNC;
                default: begin
                    if ((i_q_word.data & SYNC_BIT_MASK) != '0) begin
                        n_phase = PH_SECOND;
                    end
                end
            endcase
        end
    end

    // datapath actions of the phase machine and the other commands
    always_comb begin
        n_first    = r_first;
        n_second   = r_second;
        n_cur_x    = r_cur_x;
        n_cur_y    = r_cur_y;
        n_wr_idx   = r_wr_idx;
        n_rd_idx   = r_rd_idx;
        n_out_hit  = 1'b0;
        n_out_drop = 1'b0;
        ring_we    = 1'b0;
        wr_entry.x   = clamp_axis(sum_x, r_max_x);
        wr_entry.y   = clamp_axis(sum_y, r_max_y);
        wr_entry.dx  = r_second;
        wr_entry.dy  = i_q_word.data;
        wr_entry.btn = r_first[BTN_W-1:0];
        if (fire) begin
            case (i_q_word.kind)
                CMD_BYTE: begin
                    unique case (r_phase)
                        PH_SECOND: n_second = i_q_word.data;
                        PH_THIRD: begin
                            n_cur_x = wr_entry.x;
                            n_cur_y = wr_entry.y;
                            if (!ring_full) begin
                                ring_we  = 1'b1;
                                n_wr_idx = wr_next;
                            end else begin
                                n_out_drop = 1'b1;
                            end
                        end
                        default: begin
                            if ((i_q_word.data & SYNC_BIT_MASK) != '0) begin
                                n_first = i_q_word.data;
                            end
                        end
                    endcase
                end
                CMD_POP: begin
                    if (!ring_empty) begin
                        n_out_hit = 1'b1;
                        n_rd_idx  = rd_next;
                    end
                end
                CMD_SET: begin
                    n_cur_x = i_q_word.x;
                    n_cur_y = i_q_word.y;
                end
                default: ;
            endcase
        end
    end

    // ring fill after this step, low bits reported
    always_comb begin
        if (n_wr_idx >= n_rd_idx) begin
            cnt_ext = {1'b0, n_wr_idx} - {1'b0, n_rd_idx};
        end else begin
            cnt_ext = {1'b0, n_wr_idx} + (AW+1)'(RING_DEPTH) - {1'b0, n_rd_idx};
        end
        cnt_wide = {{CNT_W{1'b0}}, cnt_ext[AW-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_x     <= MAX_X_RESET;
            r_max_y     <= MAX_Y_RESET;
            r_phase     <= PH_SYNC;
            r_first     <= '0;
            r_second    <= '0;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
            r_out_hit   <= 1'b0;
            r_out_drop  <= 1'b0;
            r_out_count <= '0;
        end else begin
            if (i_cfg.we) begin
                unique case (i_cfg.idx)
                    REG_MAX_X: r_max_x <= i_cfg.data;
                    REG_MAX_Y: r_max_y <= i_cfg.data;
                    default: ;
                endcase
            end
            r_phase  <= n_phase;
            r_first  <= n_first;
            r_second <= n_second;
            r_cur_x  <= n_cur_x;
            r_cur_y  <= n_cur_y;
            r_wr_idx <= n_wr_idx;
            r_rd_idx <= n_rd_idx;
            if (fire) begin
                r_out_valid <= 1'b1;
                r_out_hit   <= n_out_hit;
                r_out_drop  <= n_out_drop;
                r_out_count <= cnt_wide[CNT_W-1:0];
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
                r_out_hit   <= 1'b0;
                r_out_drop  <= 1'b0;
            end
        end
    end

    // ring memory, registered read
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_mem[r_wr_idx] <= wr_entry;
        end
        if (fire) begin
            r_rd_data <= r_mem[r_rd_idx];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_packet_valid = r_out_hit;
    assign o_pos_x        = r_out_hit ? r_rd_data.x : '0;
    assign o_pos_y        = r_out_hit ? r_rd_data.y : '0;
    assign o_delta_x      = r_out_hit ? $signed(r_rd_data.dx) : '0;
    assign o_delta_y      = r_out_hit ? $signed(r_rd_data.dy) : '0;
    assign o_buttons      = r_out_hit ? r_rd_data.btn : '0;
    assign o_queued_count = r_out_count;
    assign o_dropped      = r_out_drop;

`ifndef SYNTHESIS
    a_empty_pop_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && (i_q_word.kind == CMD_POP) && ring_empty) |=> !r_out_hit)
        else $error("pop of empty ring returned a packet");

    a_cursor_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pkt_done && !i_cfg.we) |=> ((r_cur_x <= r_max_x) && (r_cur_y <= r_max_y)))
        else $error("cursor outside clamp bounds after packet");

    a_drop_keeps_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pkt_done && ring_full) |=> ($stable(r_wr_idx) && r_out_drop))
        else $error("dropped packet moved the write index");

    a_hit_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_hit || r_out_drop) |-> r_out_valid)
        else $error("result flags set without a pending result");
`endif

endmodule

// ----- rtl/ps2_mouse_packet_tracker_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ps2_mouse_packet_tracker_top
// ps/2 mouse 3-byte packet decoder with cursor tracking and a packet ring
// ---------------------------------------------------------------------------
//
//  channel   handshake                      payload
//  -------   ----------------------------   ---------------------------------
//  cfg       i_cfg_we                       i_cfg_index, i_cfg_data
//  in        i_in_valid / o_in_ready        i_operation, i_data_byte,
//                                           i_new_x, i_new_y
//  out       o_out_valid / i_out_ready      o_packet_valid, o_pos_x, o_pos_y,
//                                           o_delta_x, o_delta_y, o_buttons,
//                                           o_queued_count, o_dropped
//
//  one word per cycle sustained while the output is not stalled; a word
//  lands in the command queue at its accept edge, is executed from the queue
//  when the output register is free, and its result is registered there
//  the execute step, one clamp add per axis and one ring memory port pair,
//  sets the one-cycle rate
//  reset is synchronous and needs no clearing pass: ring slot contents are only
//  put out after they were written
//  a stalled output holds its result while the two-entry queue keeps taking
//  input words until it fills
//
module ps2_mouse_packet_tracker_top #(
    parameter int RING_DEPTH = ps2mt_pkg::RING_DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration writes
    input  logic                                 i_cfg_we,
    input  logic [ps2mt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ps2mt_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input words
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [ps2mt_pkg::OP_W-1:0]           i_operation,
    input  logic [7:0]                           i_data_byte,
    input  logic [ps2mt_pkg::AXIS_W-1:0]         i_new_x,
    input  logic [ps2mt_pkg::AXIS_W-1:0]         i_new_y,
    // result words
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_packet_valid,
    output logic [ps2mt_pkg::AXIS_W-1:0]         o_pos_x,
    output logic [ps2mt_pkg::AXIS_W-1:0]         o_pos_y,
    output logic signed [ps2mt_pkg::DELTA_W-1:0] o_delta_x,
    output logic signed [ps2mt_pkg::DELTA_W-1:0] o_delta_y,
    output logic [ps2mt_pkg::BTN_W-1:0]          o_buttons,
    output logic [ps2mt_pkg::CNT_W-1:0]          o_queued_count,
    output logic                                 o_dropped
);
    import ps2mt_pkg::*;

    t_cfg_wr   cfg_wr;
    logic      q_valid;
    logic      q_pop;
    t_cmd_word q_word;

    // bundle the write port for the back end
    assign cfg_wr.we   = i_cfg_we;
    assign cfg_wr.idx  = i_cfg_index;
    assign cfg_wr.data = i_cfg_data;

    // front: accept and classify words, buffer them
    ps2mt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_data_byte (i_data_byte),
        .i_new_x     (i_new_x),
        .i_new_y     (i_new_y),
        .o_q_valid   (q_valid),
        .o_q_word    (q_word),
        .i_q_pop     (q_pop)
    );

    // back: packet assembly, cursor, ring and result register
    ps2mt_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg_wr),
        .i_q_valid      (q_valid),
        .i_q_word       (q_word),
        .o_q_pop        (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_packet_valid (o_packet_valid),
        .o_pos_x        (o_pos_x),
        .o_pos_y        (o_pos_y),
        .o_delta_x      (o_delta_x),
        .o_delta_y      (o_delta_y),
        .o_buttons      (o_buttons),
        .o_queued_count (o_queued_count),
        .o_dropped      (o_dropped)
    );

endmodule

// ----- tb/ps2_mouse_packet_tracker_top_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ps2_mouse_packet_tracker_top_tb
// self-checking bench for the ps/2 mouse packet tracker: a scripted run of
// corner cases, then randomized packet streams under several clamp bounds,
// with random idling on both channels and one long output stall; every
// result word is checked field by field against a typed-in result or a
// cycle-free behavioral tracker kept inside the bench
// ---------------------------------------------------------------------------
module ps2_mouse_packet_tracker_top_tb;
    import ps2mt_pkg::*;

    localparam int RING_SLOTS    = RING_DEPTH_DEF;
    localparam int SCRIPT_ROWS   = 25;
    localparam int LONG_HOLD     = 80;        // cycles the receiver holds off once
    localparam int DRAIN_CYCLES  = 20;        // idle cycles after the last result before the verdict
    localparam int CYCLE_LIMIT   = 200000;

    // one result word as the bench sees it, deltas kept as raw bytes
    typedef struct packed {
        logic                pkt;
        logic [AXIS_W-1:0]   x;
        logic [AXIS_W-1:0]   y;
        logic [DELTA_W-1:0]  dx;
        logic [DELTA_W-1:0]  dy;
        logic [BTN_W-1:0]    btn;
        logic [CNT_W-1:0]    cnt;
        logic                drop;
    } report_t;

    // one scripted row: the word, and a typed-in result where it is obvious
    typedef struct packed {
        t_cmd_word w;
        logic      typed;
        report_t   want;
    } script_row_t;

    // dut inputs, all known from time zero
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  i_in_valid    = 1'b0;
    logic                  o_in_ready;
    logic [OP_W-1:0]       i_operation   = '0;
    logic [7:0]            i_data_byte   = '0;
    logic [AXIS_W-1:0]     i_new_x       = '0;
    logic [AXIS_W-1:0]     i_new_y       = '0;
    logic                  o_out_valid;
    logic                  i_out_ready   = 1'b0;
    logic                  o_packet_valid;
    logic [AXIS_W-1:0]     o_pos_x;
    logic [AXIS_W-1:0]     o_pos_y;
    logic signed [DELTA_W-1:0] o_delta_x;
    logic signed [DELTA_W-1:0] o_delta_y;
    logic [BTN_W-1:0]      o_buttons;
    logic [CNT_W-1:0]      o_queued_count;
    logic                  o_dropped;

    // tracker state mirrored in the bench
    logic [AXIS_W-1:0]  lim_x;
    logic [AXIS_W-1:0]  lim_y;
    t_phase             rx_phase;
    logic [7:0]         head_byte;      // first byte of the packet in flight
    logic [7:0]         move_x_byte;    // second byte of the packet in flight
    logic [AXIS_W-1:0]  cur_x;
    logic [AXIS_W-1:0]  cur_y;
    t_ring_entry        ring_copy [RING_SLOTS];
    int                 ring_wr;
    int                 ring_rd;

    report_t     pending_reports [$];
    script_row_t script [SCRIPT_ROWS];

    int  mismatches   = 0;
    int  words_sent   = 0;
    int  cycle_count  = 0;
    int  tx_gap_rate  = 0;     // 0: no sender idling, else roughly 1 in n+1 words
    int  rx_gap_rate  = 0;     // 0: no receiver stalls, else a stall burst starts with chance 1 in n+1
    int  stall_left   = 0;
    bit  hold_req     = 1'b0;

    ps2_mouse_packet_tracker_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_data_byte    (i_data_byte),
        .i_new_x        (i_new_x),
        .i_new_y        (i_new_y),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_packet_valid (o_packet_valid),
        .o_pos_x        (o_pos_x),
        .o_pos_y        (o_pos_y),
        .o_delta_x      (o_delta_x),
        .o_delta_y      (o_delta_y),
        .o_buttons      (o_buttons),
        .o_queued_count (o_queued_count),
        .o_dropped      (o_dropped)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog on the whole run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // behavioral tracker
    // ---------------------------------------------------------------------

    // clamp a signed sum into 0..hi
    function automatic logic [AXIS_W-1:0] bound_axis(input int v, input logic [AXIS_W-1:0] hi);
        int top;
        top = hi;
        if (v < 0)
            return '0;
        if (v > top)
            return hi;
        return v[AXIS_W-1:0];
    endfunction

    // advance the mirrored state by one word and return its result word
    function automatic report_t track_word(input t_cmd_word w);
        report_t r;
        int      sx;
        int      sy;
        int      dx;
        int      dy;
        int      nxt;
        r = '0;
        case (w.kind)
            CMD_BYTE: begin
                case (rx_phase)
                    PH_SECOND: begin
                        move_x_byte = w.data;
                        rx_phase    = PH_THIRD;
                    end
                    PH_THIRD: begin
                        rx_phase = PH_SYNC;
                        sx = cur_x;
                        sy = cur_y;
                        dx = $signed(move_x_byte);
                        dy = $signed(w.data);
                        // screen y grows downward, mouse y grows upward
                        cur_x = bound_axis(sx + dx, lim_x);
                        cur_y = bound_axis(sy - dy, lim_y);
                        nxt = (ring_wr + 1) % RING_SLOTS;
                        if (nxt != ring_rd) begin
                            ring_copy[ring_wr] = '{cur_x, cur_y, move_x_byte, w.data,
                                                   head_byte[BTN_W-1:0]};
                            ring_wr = nxt;
                        end else begin
                            r.drop = 1'b1;
                        end
                    end
                    default: begin
                        // only a byte with the sync bit can open a packet
                        if ((w.data & SYNC_BIT_MASK) != 0) begin
                            head_byte = w.data;
                            rx_phase  = PH_SECOND;
                        end
                    end
                endcase
            end
            CMD_POP: begin
                if (ring_rd != ring_wr) begin
                    r.pkt = 1'b1;
                    r.x   = ring_copy[ring_rd].x;
                    r.y   = ring_copy[ring_rd].y;
                    r.dx  = ring_copy[ring_rd].dx;
                    r.dy  = ring_copy[ring_rd].dy;
                    r.btn = ring_copy[ring_rd].btn;
                    ring_rd = (ring_rd + 1) % RING_SLOTS;
                end
            end
            CMD_SET: begin
                // loaded as given, the next packet clamps again
                cur_x = w.x;
                cur_y = w.y;
            end
            default: ;
        endcase
        r.cnt = CNT_W'((ring_wr + RING_SLOTS - ring_rd) % RING_SLOTS);
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------------

    function automatic report_t quiet_report(input logic [CNT_W-1:0] cnt);
        report_t r;
        r     = '0;
        r.cnt = cnt;
        return r;
    endfunction

    function automatic script_row_t row(input t_cmd_kind k, input logic [7:0] d,
                                        input logic [AXIS_W-1:0] nx,
                                        input logic [AXIS_W-1:0] ny,
                                        input logic typed, input report_t want);
        script_row_t s;
        s.w.kind = k;
        s.w.data = d;
        s.w.x    = nx;
        s.w.y    = ny;
        s.typed  = typed;
        s.want   = want;
        return s;
    endfunction

    // offer one word and hold it until taken; handshake sampled mid-cycle
    // so the accept edge is known without racing the dut's registers
    task automatic put_word(input t_cmd_word w, input logic typed, input report_t want);
        bit      took;
        report_t predicted;
        if (tx_gap_rate != 0 && $urandom_range(0, tx_gap_rate) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= w.kind;
        i_data_byte <= w.data;
        i_new_x     <= w.x;
        i_new_y     <= w.y;
        took = 1'b0;
        while (!took) begin
            @(negedge i_clk);
            took = o_in_ready;
            if (took) begin
                predicted = track_word(w);
                pending_reports.push_back(typed ? want : predicted);
                words_sent++;
            end
            @(posedge i_clk);
        end
    endtask

    // wait until every result is back, then a few spare cycles
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // both clamp bounds, written back to back with the enable held high
    task automatic write_bounds(input logic [AXIS_W-1:0] bx, input logic [AXIS_W-1:0] by);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_MAX_X;
        i_cfg_data  <= bx;
        @(posedge i_clk);
        i_cfg_index <= REG_MAX_Y;
        i_cfg_data  <= by;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        lim_x = bx;
        lim_y = by;
    endtask

    // mostly well-formed packets with random content, plus pops, position
    // loads, unused opcodes, stray bytes and the odd interrupted packet
    task automatic random_words(input int count, input int pop_pct);
        int        goal;
        int        pick;
        t_cmd_word w;
        goal = words_sent + count;
        while (words_sent < goal) begin
            pick   = $urandom_range(0, 99);
            w.data = 8'($urandom_range(0, 255));
            w.x    = AXIS_W'($urandom_range(0, 65535));
            w.y    = AXIS_W'($urandom_range(0, 65535));
            if (pick < pop_pct) begin
                w.kind = CMD_POP;
                put_word(w, 1'b0, '0);
            end else if (pick < pop_pct + 5) begin
                w.kind = CMD_SET;
                if ($urandom_range(0, 1) == 1) begin
                    w.x = AXIS_W'($urandom_range(0, lim_x));
                    w.y = AXIS_W'($urandom_range(0, lim_y));
                end
                put_word(w, 1'b0, '0);
            end else if (pick < pop_pct + 9) begin
                w.kind = CMD_IDLE;
                put_word(w, 1'b0, '0);
            end else if (pick < pop_pct + 15) begin
                // stray byte, may knock the framing off
                w.kind = CMD_BYTE;
                put_word(w, 1'b0, '0);
            end else begin
                w.kind = CMD_BYTE;
                w.data = w.data | SYNC_BIT_MASK;
                put_word(w, 1'b0, '0);
                w.data = 8'($urandom_range(0, 255));
                put_word(w, 1'b0, '0);
                if ($urandom_range(0, 15) == 0) begin
                    // pop in the middle of a packet
                    w.kind = CMD_POP;
                    put_word(w, 1'b0, '0);
                    w.kind = CMD_BYTE;
                end
                w.data = 8'($urandom_range(0, 255));
                put_word(w, 1'b0, '0);
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // receiver: random stall bursts, plus one long hold-off on request
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req   = 1'b0;
            stall_left = LONG_HOLD;
        end
        if (stall_left != 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (rx_gap_rate != 0 && $urandom_range(0, rx_gap_rate) == 0) begin
            stall_left = $urandom_range(1, 11) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------------
    // result checker: payload sampled mid-cycle, taken at the next edge
    // ---------------------------------------------------------------------
    task automatic check_field(input string name, input logic [AXIS_W-1:0] want_v,
                               input logic [AXIS_W-1:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(negedge i_clk) begin : check_result
        report_t got;
        report_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.pkt  = o_packet_valid;
            got.x    = o_pos_x;
            got.y    = o_pos_y;
            got.dx   = o_delta_x;
            got.dy   = o_delta_y;
            got.btn  = o_buttons;
            got.cnt  = o_queued_count;
            got.drop = o_dropped;
            if (pending_reports.size() == 0) begin
                $display("%0t: result word with none expected, expected nothing, got %h",
                         $time, got);
                mismatches++;
            end else begin
                want = pending_reports.pop_front();
                check_field("packet_valid", want.pkt,  got.pkt);
                check_field("pos_x",        want.x,    got.x);
                check_field("pos_y",        want.y,    got.y);
                check_field("delta_x",      want.dx,   got.dx);
                check_field("delta_y",      want.dy,   got.dy);
                check_field("buttons",      want.btn,  got.btn);
                check_field("queued_count", want.cnt,  got.cnt);
                check_field("dropped",      want.drop, got.drop);
            end
        end
    end

    // ---------------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------------
    initial begin
        // mirrored state after reset
        lim_x       = MAX_X_RESET;
        lim_y       = MAX_Y_RESET;
        rx_phase    = PH_SYNC;
        head_byte   = '0;
        move_x_byte = '0;
        cur_x       = '0;
        cur_y       = '0;
        ring_wr     = 0;
        ring_rd     = 0;

        // scripted corner cases, run at the reset bounds 1023 x 767
        script[0]  = row(CMD_POP,  8'h00, 16'h0000, 16'h0000, 1'b1, quiet_report(4'd0));
        // unused opcode with every bit set
        script[1]  = row(CMD_IDLE, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, quiet_report(4'd0));
        // no sync bit, ignored
        script[2]  = row(CMD_BYTE, 8'hF7, 16'h0000, 16'h0000, 1'b1, quiet_report(4'd0));
        // all buttons, full positive x, full negative y
        script[3]  = row(CMD_BYTE, 8'hFF, 16'h0000, 16'h0000, 1'b1, quiet_report(4'd0));
        script[4]  = row(CMD_BYTE, 8'h7F, 16'h0000, 16'h0000, 1'b1, quiet_report(4'd0));
        script[5]  = row(CMD_BYTE, 8'h80, 16'h0000, 16'h0000, 1'b1, quiet_report(4'd1));
        script[6]  = row(CMD_POP,  8'h00, 16'h0000, 16'h0000, 1'b1,
                         '{1'b1, 16'd127, 16'd128, 8'h7F, 8'h80, 3'd7, 4'd0, 1'b0});
        // load past the bounds, unclamped
        script[7]  = row(CMD_SET,  8'h00, 16'hFFFF, 16'hFFFF, 1'b1, quiet_report(4'd0));
        // next packet pulls both axes back to the upper bound
        script[8]  = row(CMD_BYTE, 8'h08, 16'h0000, 16'h0000, 1'b0, '0);
        script[9]  = row(CMD_BYTE, 8'h80, 16'h0000, 16'h0000, 1'b0, '0);
        script[10] = row(CMD_BYTE, 8'h7F, 16'h0000, 16'h0000, 1'b0, '0);
        script[11] = row(CMD_SET,  8'h00, 16'h0000, 16'h0000, 1'b0, '0);
        // small moves below zero clamp at the lower bound
        script[12] = row(CMD_BYTE, 8'h09, 16'h0000, 16'h0000, 1'b0, '0);
        script[13] = row(CMD_BYTE, 8'hFF, 16'h0000, 16'h0000, 1'b0, '0);
        script[14] = row(CMD_BYTE, 8'h01, 16'h0000, 16'h0000, 1'b0, '0);
        script[15] = row(CMD_POP,  8'h00, 16'h0000, 16'h0000, 1'b0, '0);
        script[16] = row(CMD_POP,  8'h00, 16'h0000, 16'h0000, 1'b0, '0);
        // ring empty again
        script[17] = row(CMD_POP,  8'h00, 16'h0000, 16'h0000, 1'b1, quiet_report(4'd0));
        // zero movement
        script[18] = row(CMD_BYTE, 8'h0A, 16'h0000, 16'h0000, 1'b0, '0);
        script[19] = row(CMD_BYTE, 8'h00, 16'h0000, 16'h0000, 1'b0, '0);
        script[20] = row(CMD_BYTE, 8'h00, 16'h0000, 16'h0000, 1'b0, '0);
        // pop between the first and second byte of a packet
        script[21] = row(CMD_BYTE, 8'h08, 16'h0000, 16'h0000, 1'b0, '0);
        script[22] = row(CMD_POP,  8'h00, 16'h0000, 16'h0000, 1'b0, '0);
        script[23] = row(CMD_BYTE, 8'h05, 16'h0000, 16'h0000, 1'b0, '0);
        script[24] = row(CMD_BYTE, 8'hFB, 16'h0000, 16'h0000, 1'b0, '0);

        // hold the synchronous reset, then release it
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_gap_rate = 3;
        rx_gap_rate = 6;
        foreach (script[i])
            put_word(script[i].w, script[i].typed, script[i].want);

        // both bounds at zero: every packet lands on the origin
        settle();
        write_bounds(16'h0000, 16'h0000);
        random_words(80, 25);

        // bounds wide open, plus a long output stall that backs up the input
        settle();
        write_bounds(16'hFFFF, 16'hFFFF);
        tx_gap_rate = 0;
        hold_req    = 1'b1;
        random_words(40, 0);
        tx_gap_rate = 4;
        random_words(60, 10);

        // random bounds, few pops, no idling: ring fills and drops packets
        settle();
        write_bounds(AXIS_W'($urandom_range(0, 65535)), AXIS_W'($urandom_range(0, 65535)));
        tx_gap_rate = 0;
        rx_gap_rate = 0;
        random_words(100, 3);

        // back to the reset bounds, heavy idling and pops to drain the ring
        settle();
        write_bounds(MAX_X_RESET, MAX_Y_RESET);
        tx_gap_rate = 2;
        rx_gap_rate = 3;
        random_words(120, 40);

        // closing stretch with no idling at all
        tx_gap_rate = 0;
        rx_gap_rate = 0;
        random_words(100, 20);

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/ps2mt_pkg.sv
rtl/ps2mt_front.sv
rtl/ps2mt_back.sv
rtl/ps2_mouse_packet_tracker_top.sv
tb/ps2_mouse_packet_tracker_top_tb.sv
